[sv/klca_pkg.sv]
package klca_pkg;

    // fixed payload widths
    localparam int KEY_W   = 64;
    localparam int COUNT_W = 9;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // relationship codes
    typedef enum logic [2:0] {
        REL_ANCESTOR   = 3'd0,
        REL_DESCENDANT = 3'd1,
        REL_SIBLING    = 3'd2,
        REL_COUSIN     = 3'd3,
        REL_REMOVED    = 3'd4,
        REL_NONE       = 3'd5
    } rel_t;

    // operation codes
    typedef enum logic {
        OP_LINK  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

endpackage

[sv/klca_if.sv]
// request channel: one link or query transaction
interface klca_req_if
    import klca_pkg::*;
;
    logic             valid;
    logic             ready;
    op_t              operation;
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] second_key;

    modport source (output valid, operation, first_key, second_key, input ready);
    modport sink   (input valid, operation, first_key, second_key, output ready);
endinterface

// response channel: one result transaction per request
interface klca_rsp_if
    import klca_pkg::*;
;
    logic               valid;
    logic               ready;
    status_t            status;
    rel_t               relation;
    logic [COUNT_W-1:0] generations;
    logic [COUNT_W-1:0] cousin_degree;
    logic [COUNT_W-1:0] removal;

    modport source (output valid, status, relation, generations, cousin_degree, removal,
                    input ready);
    modport sink   (input valid, status, relation, generations, cousin_degree, removal,
                    output ready);
endinterface

[sv/klca_ram.sv]
module klca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/kinship_table_lca_query_unit.sv]
// Kinship table with lowest-common-ancestor queries. Keys and parent links
// live in two single-port-read RAMs walked by one small sequencer, so the
// block takes one transaction at a time and is not ready while it works.
// Every table read has an address state, then a registered-data state. A
// link does the key scan over the N entries in use, an optional parent
// read and up to two writes. A query does the same scan, then up to two
// ancestor climbs of one parent read per generation, then, for cousins, one
// climb from the second key for each ancestor of the first key. The result
// sits in an output register, so the next request is taken while an earlier
// result still waits. No clearing pass is needed after reset.
module kinship_table_lca_query_unit
    import klca_pkg::*;
#(
    parameter int ENTRIES  = 512,
    parameter int KEY_BITS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    klca_req_if.sink  req,
    klca_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int PAR_W = IDX_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_LINK_RD,
        S_LINK_CHK,
        S_WR_A,
        S_WR_B,
        S_CL_RD,
        S_CL_CHK,
        S_OUT_RD,
        S_OUT_CHK,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        LK_SET,
        LK_NEWPAR,
        LK_NEWCHILD,
        LK_NEWBOTH
    } lcase_t;

    typedef enum logic [1:0] {
        PH_ANC,
        PH_DESC,
        PH_COUS
    } phase_t;

    state_t              state_reg;
    lcase_t              lcase_reg;
    phase_t              phase_reg;
    op_t                 op_reg;
    logic [KEY_BITS-1:0] k1_reg;
    logic [KEY_BITS-1:0] k2_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic                f1_reg;
    logic                f2_reg;
    logic [IDX_W-1:0]    i1_reg;
    logic [IDX_W-1:0]    i2_reg;
    logic [IDX_W-1:0]    cl_r_reg;
    logic [IDX_W-1:0]    cl_anc_reg;
    logic [CNT_W-1:0]    cl_n_reg;
    logic [IDX_W-1:0]    o_r_reg;
    logic [CNT_W-1:0]    m_reg;

    status_t             res_status_reg;
    rel_t                res_rel_reg;
    logic [COUNT_W-1:0]  res_gen_reg;
    logic [COUNT_W-1:0]  res_deg_reg;
    logic [COUNT_W-1:0]  res_rem_reg;

    logic                out_valid_reg;
    status_t             out_status_reg;
    rel_t                out_rel_reg;
    logic [COUNT_W-1:0]  out_gen_reg;
    logic [COUNT_W-1:0]  out_deg_reg;
    logic [COUNT_W-1:0]  out_rem_reg;

    // memory ports
    logic                key_we;
    logic [IDX_W-1:0]    key_waddr;
    logic [KEY_BITS-1:0] key_wdata;
    logic [KEY_BITS-1:0] key_rdata;
    logic                par_we;
    logic [IDX_W-1:0]    par_waddr;
    logic [PAR_W-1:0]    par_wdata;
    logic [IDX_W-1:0]    par_raddr;
    logic [PAR_W-1:0]    par_rdata;

    logic                par_valid;
    logic [IDX_W-1:0]    par_idx;
    logic [IDX_W-1:0]    next_idx;
    logic [IDX_W-1:0]    next_idx1;
    logic [CNT_W-1:0]    lo;
    logic [CNT_W-1:0]    diff;
    logic                req_fire;
    logic                rsp_fire;

    klca_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    klca_ram #(.WIDTH(PAR_W), .DEPTH(ENTRIES)) u_par_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;
    assign par_valid = par_rdata[IDX_W];
    assign par_idx   = par_rdata[IDX_W-1:0];
    assign next_idx  = cnt_reg[IDX_W-1:0];
    assign next_idx1 = cnt_reg[IDX_W-1:0] + IDX_W'(1);

    // cousin distances from the two climb counts
    always_comb
    begin
        if (cl_n_reg > m_reg)
        begin
            lo   = m_reg;
            diff = cl_n_reg - m_reg;
        end
        else
        begin
            lo   = cl_n_reg;
            diff = m_reg - cl_n_reg;
        end
    end

    // parent read address follows the walk in progress
    always_comb
    begin
        unique case (state_reg)
            S_LINK_RD: par_raddr = i1_reg;
            S_OUT_RD:  par_raddr = o_r_reg;
            default:   par_raddr = cl_r_reg;
        endcase
    end

    // table writes for the link cases
    always_comb
    begin
        key_we    = 1'b0;
        key_waddr = next_idx;
        key_wdata = k1_reg;
        par_we    = 1'b0;
        par_waddr = next_idx;
        par_wdata = '0;
        if (state_reg == S_WR_A)
        begin
            unique case (lcase_reg)
                LK_SET:
                begin
                    par_we    = 1'b1;
                    par_waddr = i1_reg;
                    par_wdata = {1'b1, i2_reg};
                end
                LK_NEWPAR:
                begin
                    par_we    = 1'b1;
                    par_waddr = i1_reg;
                    par_wdata = {1'b1, next_idx};
                end
                LK_NEWCHILD:
                begin
                    key_we    = 1'b1;
                    par_we    = 1'b1;
                    par_wdata = {1'b1, i2_reg};
                end
                LK_NEWBOTH:
                begin
                    key_we    = 1'b1;
                    par_we    = 1'b1;
                    par_wdata = {1'b1, next_idx1};
                end
            endcase
        end
        else if (state_reg == S_WR_B)
        begin
            key_we    = 1'b1;
            par_we    = 1'b1;
            key_wdata = k2_reg;
            if (lcase_reg == LK_NEWBOTH)
            begin
                key_waddr = next_idx1;
                par_waddr = next_idx1;
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the finish state reloads the output register itself
            if (rsp_fire && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        op_reg         <= req.operation;
                        k1_reg         <= req.first_key[KEY_BITS-1:0];
                        k2_reg         <= req.second_key[KEY_BITS-1:0];
                        scan_reg       <= '0;
                        f1_reg         <= 1'b0;
                        f2_reg         <= 1'b0;
                        res_status_reg <= ST_OK;
                        res_rel_reg    <= REL_NONE;
                        res_gen_reg    <= '0;
                        res_deg_reg    <= '0;
                        res_rem_reg    <= '0;
                        state_reg      <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    if (scan_reg != cnt_reg)
                    begin
                        state_reg <= S_SCAN_CMP;
                    end
                    else if (op_reg == OP_QUERY)
                    begin
                        if (f1_reg && f2_reg)
                        begin
                            cl_anc_reg <= i1_reg;
                            cl_r_reg   <= i2_reg;
                            cl_n_reg   <= '0;
                            phase_reg  <= PH_ANC;
                            state_reg  <= S_CL_RD;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                    else if (f1_reg)
                    begin
                        state_reg <= S_LINK_RD;
                    end
                    else if (f2_reg)
                    begin
                        if (cnt_reg == CNT_W'(ENTRIES))
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_FIN;
                        end
                        else
                        begin
                            lcase_reg <= LK_NEWCHILD;
                            state_reg <= S_WR_A;
                        end
                    end
                    else if (cnt_reg >= CNT_W'(ENTRIES - 1))
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_FIN;
                    end
                    else
                    begin
                        lcase_reg <= LK_NEWBOTH;
                        state_reg <= S_WR_A;
                    end
                end
                S_SCAN_CMP:
                begin
                    // first match wins for each key
                    if (!f1_reg && key_rdata == k1_reg)
                    begin
                        f1_reg <= 1'b1;
                        i1_reg <= scan_reg[IDX_W-1:0];
                    end
                    if (!f2_reg && key_rdata == k2_reg)
                    begin
                        f2_reg <= 1'b1;
                        i2_reg <= scan_reg[IDX_W-1:0];
                    end
                    scan_reg  <= scan_reg + CNT_W'(1);
                    state_reg <= S_SCAN_RD;
                end
                S_LINK_RD:
                begin
                    state_reg <= S_LINK_CHK;
                end
                S_LINK_CHK:
                begin
                    // conflict check comes before the full check
                    if (f2_reg)
                    begin
                        if (par_valid && par_idx != i2_reg)
                        begin
                            res_status_reg <= ST_CONFLICT;
                            state_reg      <= S_FIN;
                        end
                        else
                        begin
                            lcase_reg <= LK_SET;
                            state_reg <= S_WR_A;
                        end
                    end
                    else if (par_valid)
                    begin
                        res_status_reg <= ST_CONFLICT;
                        state_reg      <= S_FIN;
                    end
                    else if (cnt_reg == CNT_W'(ENTRIES))
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_FIN;
                    end
                    else
                    begin
                        lcase_reg <= LK_NEWPAR;
                        state_reg <= S_WR_A;
                    end
                end
                S_WR_A:
                begin
                    unique case (lcase_reg)
                        LK_SET:
                        begin
                            state_reg <= S_FIN;
                        end
                        LK_NEWCHILD:
                        begin
                            cnt_reg   <= cnt_reg + CNT_W'(1);
                            state_reg <= S_FIN;
                        end
                        default:
                        begin
                            state_reg <= S_WR_B;
                        end
                    endcase
                end
                S_WR_B:
                begin
                    if (lcase_reg == LK_NEWBOTH)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(2);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    state_reg <= S_FIN;
                end
                S_CL_RD:
                begin
                    if (cl_n_reg == CNT_W'(ENTRIES))
                    begin
                        // climb gave up: target not reached
                        unique case (phase_reg)
                            PH_ANC:
                            begin
                                cl_anc_reg <= i2_reg;
                                cl_r_reg   <= i1_reg;
                                cl_n_reg   <= '0;
                                phase_reg  <= PH_DESC;
                                state_reg  <= S_CL_RD;
                            end
                            PH_DESC:
                            begin
                                o_r_reg   <= i1_reg;
                                m_reg     <= '0;
                                state_reg <= S_OUT_RD;
                            end
                            default:
                            begin
                                m_reg     <= m_reg + CNT_W'(1);
                                state_reg <= S_OUT_RD;
                            end
                        endcase
                    end
                    else
                    begin
                        state_reg <= S_CL_CHK;
                    end
                end
                S_CL_CHK:
                begin
                    if (par_valid && par_idx == cl_anc_reg)
                    begin
                        // target reached
                        unique case (phase_reg)
                            PH_ANC:
                            begin
                                res_rel_reg <= REL_ANCESTOR;
                                res_gen_reg <= COUNT_W'(cl_n_reg);
                            end
                            PH_DESC:
                            begin
                                res_rel_reg <= REL_DESCENDANT;
                                res_gen_reg <= COUNT_W'(cl_n_reg);
                            end
                            default:
                            begin
                                if (lo == '0 && diff == '0)
                                begin
                                    res_rel_reg <= REL_SIBLING;
                                end
                                else if (diff == '0)
                                begin
                                    res_rel_reg <= REL_COUSIN;
                                end
                                else
                                begin
                                    res_rel_reg <= REL_REMOVED;
                                end
                                res_deg_reg <= COUNT_W'(lo);
                                res_rem_reg <= COUNT_W'(diff);
                            end
                        endcase
                        state_reg <= S_FIN;
                    end
                    else if (!par_valid)
                    begin
                        // hit a root without reaching the target
                        unique case (phase_reg)
                            PH_ANC:
                            begin
                                cl_anc_reg <= i2_reg;
                                cl_r_reg   <= i1_reg;
                                cl_n_reg   <= '0;
                                phase_reg  <= PH_DESC;
                                state_reg  <= S_CL_RD;
                            end
                            PH_DESC:
                            begin
                                o_r_reg   <= i1_reg;
                                m_reg     <= '0;
                                state_reg <= S_OUT_RD;
                            end
                            default:
                            begin
                                m_reg     <= m_reg + CNT_W'(1);
                                state_reg <= S_OUT_RD;
                            end
                        endcase
                    end
                    else
                    begin
                        cl_r_reg  <= par_idx;
                        cl_n_reg  <= cl_n_reg + CNT_W'(1);
                        state_reg <= S_CL_RD;
                    end
                end
                S_OUT_RD:
                begin
                    if (m_reg == CNT_W'(ENTRIES))
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_OUT_CHK;
                    end
                end
                S_OUT_CHK:
                begin
                    // step the first key up one, then climb from the second
                    if (!par_valid)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        o_r_reg    <= par_idx;
                        cl_anc_reg <= par_idx;
                        cl_r_reg   <= i2_reg;
                        cl_n_reg   <= '0;
                        phase_reg  <= PH_COUS;
                        state_reg  <= S_CL_RD;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_rel_reg    <= res_rel_reg;
                        out_gen_reg    <= res_gen_reg;
                        out_deg_reg    <= res_deg_reg;
                        out_rem_reg    <= res_rem_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // handshake outputs
    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.relation      = out_rel_reg;
    assign rsp.generations   = out_gen_reg;
    assign rsp.cousin_degree = out_deg_reg;
    assign rsp.removal       = out_rem_reg;

endmodule

[sv/klca_checker.sv]
module klca_checker
    import klca_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input status_t            rsp_status,
    input rel_t               rsp_relation,
    input logic [COUNT_W-1:0] rsp_generations,
    input logic [COUNT_W-1:0] rsp_cousin_degree,
    input logic [COUNT_W-1:0] rsp_removal
);

    // the block works on one transaction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a transaction is in progress");

    // a rejected link never carries a relation
    a_reject_no_rel: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_relation == REL_NONE)
        else $error("rejected link reports a relation");

    // generation count only for direct lines
    a_gen_only_line: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_relation != REL_ANCESTOR && rsp_relation != REL_DESCENDANT
        |-> rsp_generations == '0)
        else $error("generations set outside ancestor or descendant");

    // cousin fields only for collateral relations, and zero for siblings
    a_cousin_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_relation == REL_ANCESTOR || rsp_relation == REL_DESCENDANT
        || rsp_relation == REL_NONE || rsp_relation == REL_SIBLING)
        |-> rsp_cousin_degree == '0 && rsp_removal == '0)
        else $error("cousin fields set for a non-cousin relation");

    // a removed cousin has a nonzero removal (a plain cousin has none)
    a_removal_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_relation == REL_REMOVED |-> rsp_removal != '0)
        else $error("removed cousin with zero removal");

endmodule

bind kinship_table_lca_query_unit klca_checker u_klca_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_status        (rsp.status),
    .rsp_relation      (rsp.relation),
    .rsp_generations   (rsp.generations),
    .rsp_cousin_degree (rsp.cousin_degree),
    .rsp_removal       (rsp.removal)
);
